// ===== design/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_msg;
	} item_t;

	typedef struct packed {
		logic [63:0] digest_bits_255_192;
		logic [63:0] digest_bits_191_128;
		logic [63:0] digest_bits_127_64;
		logic [63:0] digest_bits_63_0;
	} digest_t;

	typedef logic [0:7][31:0] words8_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KICK,
		ST_COMP,
		ST_PAD,
		ST_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_RUN,
		CORE_FOLD
	} core_state_t;

	typedef struct packed {
		logic start;
		logic init;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	localparam logic [7:0]  PadByte    = 8'h80;
	localparam logic [5:0]  LenBytePos = 6'd56;
	localparam logic [5:0]  LastByte   = 6'd63;
	localparam logic [5:0]  LastRound  = 6'd63;
	localparam logic [63:0] BlockBits  = 64'd512;

	localparam words8_t HashInit = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== design/sha256_round.sv =====
`timescale 1ns / 1ps

// One compression round plus one message schedule step.
module sha256_round (
	input  sha256_pkg::words8_t v,
	input  logic [31:0]         k,
	input  logic [31:0]         w0,
	input  logic [31:0]         w1,
	input  logic [31:0]         w9,
	input  logic [31:0]         w14,
	output sha256_pkg::words8_t v_next,
	output logic [31:0]         w_new
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

	always_comb begin
		big_s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
		big_s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
		ch     = (v[4] & v[5]) ^ (~v[4] & v[6]);
		maj    = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1     = v[7] + big_s1 + ch + k + w0;
		t2     = big_s0 + maj;

		v_next[0] = t1 + t2;
		v_next[1] = v[0];
		v_next[2] = v[1];
		v_next[3] = v[2];
		v_next[4] = v[3] + t1;
		v_next[5] = v[4];
		v_next[6] = v[5];
		v_next[7] = v[6];

		sm0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		sm1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = sm1 + w9 + sm0 + w0;
	end

endmodule

// ===== design/sha256_core.sv =====
`timescale 1ns / 1ps

// Compression engine: one round per cycle through the shared round unit,
// then a fold state that adds the working words into the chaining words.
module sha256_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::core_ctl_t  ctl,
	input  logic [511:0]           block,
	output sha256_pkg::core_stat_t stat,
	output sha256_pkg::words8_t    hash
);

	sha256_pkg::core_state_t state_q, state_d;
	sha256_pkg::words8_t     hash_q, v_q, v_next;
	logic [15:0][31:0]       w_q;
	logic [31:0]             w_new;
	logic [5:0]              rnd_q;

	sha256_round u_round (
		.v      (v_q),
		.k      (sha256_pkg::RoundK[rnd_q]),
		.w0     (w_q[0]),
		.w1     (w_q[1]),
		.w9     (w_q[9]),
		.w14    (w_q[14]),
		.v_next (v_next),
		.w_new  (w_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::CORE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stat.busy = 1'b1;
		stat.done = 1'b0;
		case (state_q)
			sha256_pkg::CORE_IDLE: begin
				stat.busy = 1'b0;
				if (ctl.start) begin
					state_d = sha256_pkg::CORE_RUN;
				end
			end
			sha256_pkg::CORE_RUN: begin
				if (rnd_q == sha256_pkg::LastRound) begin
					state_d = sha256_pkg::CORE_FOLD;
				end
			end
			sha256_pkg::CORE_FOLD: begin
				stat.done = 1'b1;
				state_d   = sha256_pkg::CORE_IDLE;
			end
			default: begin
				state_d = sha256_pkg::CORE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sha256_pkg::HashInit;
		end else if (ctl.init) begin
			hash_q <= sha256_pkg::HashInit;
		end else if (state_q == sha256_pkg::CORE_FOLD) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	// working words, schedule window and round count carry no reset
	always_ff @(posedge clk) begin
		if (state_q == sha256_pkg::CORE_IDLE && ctl.start) begin
			v_q   <= hash_q;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= block[511 - 32 * i -: 32];
			end
		end else if (state_q == sha256_pkg::CORE_RUN) begin
			v_q   <= v_next;
			rnd_q <= rnd_q + 6'd1;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

	assign hash = hash_q;

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// SHA-256 over a byte stream.
// Input channel item_valid/item_ready/item carries one byte (has_byte) and
// an end flag (end_of_msg); an item with end_of_msg and no byte closes the
// message without adding data. Output channel digest_valid/digest_ready/
// digest carries one 256-bit digest per message.
// The 64th byte of a block starts a compression: a start state, 64 rounds
// in the shared round unit and a fold state, during all of which
// item_ready is low. At the end of a message the pad bytes (0x80, zeros,
// 64-bit length) are shifted into the block buffer one per cycle, with one
// or two compressions; the done state then moves the chaining words into
// the digest register once that register is free.
// The digest register is separate from the hashing state: the next message
// streams in while a digest waits, and only the next digest load waits for
// digest_ready.
// Reset restores the initial chaining words, empties the block buffer and
// clears the bit count; no digest is pending after reset.
module sha256_byte_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  sha256_pkg::item_t   item,
	output logic                digest_valid,
	input  logic                digest_ready,
	output sha256_pkg::digest_t digest
);

	sha256_pkg::ctl_state_t state_q, state_d;
	sha256_pkg::core_ctl_t  core_ctl;
	sha256_pkg::core_stat_t core_stat;
	sha256_pkg::words8_t    hash;
	sha256_pkg::digest_t    out_q;

	logic [511:0] blk_q;
	logic [5:0]   cnt_q;
	logic [63:0]  bits_q, len_q;
	logic         end_pend_q, pad_mode_q, pad_first_q, fin_blk_q, out_valid_q;

	logic         shift_en, enter_pad, load_out, data_wrap, fin_set, len_shift;
	logic [7:0]   shift_byte, pad_byte;

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (core_ctl),
		.block  (blk_q),
		.stat   (core_stat),
		.hash   (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// length bytes go in positions 56..63 of the last block only
	assign len_shift = !pad_first_q && fin_blk_q && (cnt_q >= sha256_pkg::LenBytePos);
	assign pad_byte  = pad_first_q ? sha256_pkg::PadByte :
	                   (len_shift ? len_q[63:56] : 8'h00);

	always_comb begin
		state_d       = state_q;
		item_ready    = 1'b0;
		shift_en      = 1'b0;
		shift_byte    = pad_byte;
		enter_pad     = 1'b0;
		load_out      = 1'b0;
		data_wrap     = 1'b0;
		fin_set       = 1'b0;
		core_ctl.start = 1'b0;
		core_ctl.init  = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					if (item.has_byte) begin
						shift_en   = 1'b1;
						shift_byte = item.msg_byte;
						if (cnt_q == sha256_pkg::LastByte) begin
							data_wrap = 1'b1;
							state_d   = sha256_pkg::ST_KICK;
						end else if (item.end_of_msg) begin
							enter_pad = 1'b1;
							state_d   = sha256_pkg::ST_PAD;
						end
					end else if (item.end_of_msg) begin
						enter_pad = 1'b1;
						state_d   = sha256_pkg::ST_PAD;
					end
				end
			end
			sha256_pkg::ST_KICK: begin
				core_ctl.start = 1'b1;
				state_d        = sha256_pkg::ST_COMP;
			end
			sha256_pkg::ST_COMP: begin
				if (core_stat.done) begin
					if (pad_mode_q) begin
						if (fin_blk_q) begin
							state_d = sha256_pkg::ST_DONE;
						end else begin
							fin_set = 1'b1;
							state_d = sha256_pkg::ST_PAD;
						end
					end else if (end_pend_q) begin
						enter_pad = 1'b1;
						state_d   = sha256_pkg::ST_PAD;
					end else begin
						state_d = sha256_pkg::ST_IDLE;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				shift_en = 1'b1;
				if (cnt_q == sha256_pkg::LastByte) begin
					state_d = sha256_pkg::ST_KICK;
				end
			end
			sha256_pkg::ST_DONE: begin
				if (!out_valid_q || digest_ready) begin
					load_out      = 1'b1;
					core_ctl.init = 1'b1;
					state_d       = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			bits_q      <= '0;
			end_pend_q  <= 1'b0;
			pad_mode_q  <= 1'b0;
			pad_first_q <= 1'b0;
			fin_blk_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (data_wrap) begin
				bits_q     <= bits_q + sha256_pkg::BlockBits;
				end_pend_q <= item.end_of_msg;
			end
			if (enter_pad) begin
				pad_mode_q  <= 1'b1;
				pad_first_q <= 1'b1;
			end else if (state_q == sha256_pkg::ST_PAD) begin
				pad_first_q <= 1'b0;
			end
			// 0x80 at position 56 or later pushes the length into an extra block
			if (state_q == sha256_pkg::ST_PAD && pad_first_q) begin
				fin_blk_q <= (cnt_q < sha256_pkg::LenBytePos);
			end else if (fin_set) begin
				fin_blk_q <= 1'b1;
			end
			if (load_out) begin
				bits_q      <= '0;
				end_pend_q  <= 1'b0;
				pad_mode_q  <= 1'b0;
				fin_blk_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end
		// a byte that arrives with the end flag counts toward the length
		if (enter_pad) begin
			len_q <= bits_q + {55'd0, cnt_q, 3'b000} + (shift_en ? 64'd8 : 64'd0);
		end else if (state_q == sha256_pkg::ST_PAD && len_shift) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (load_out) begin
			out_q <= sha256_pkg::digest_t'(hash);
		end
	end

	assign digest_valid = out_valid_q;
	assign digest       = out_q;

`ifndef SYNTHESIS
	a_ready_core_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !core_stat.busy)
		else $error("input taken while compression runs");

	a_kick_starts_core: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_KICK |=> core_stat.busy)
		else $error("compression did not start");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.done |-> state_q == sha256_pkg::ST_COMP)
		else $error("compression finished while not awaited");

	a_done_block_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha256_pkg::ST_DONE |-> (cnt_q == 6'd0 && fin_blk_q))
		else $error("digest with partial block");
`endif

endmodule

// ===== tb/sha256_digest_check_pkg.sv =====
`timescale 1ns / 1ps

package sha256_digest_check_pkg;

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] START_WORDS [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	class digest_scoreboard;
		logic [31:0]         chain [8];
		logic [7:0]          blk [64];
		int                  fill;
		logic [63:0]         bits_done;
		sha256_pkg::digest_t want_q [$];
		int                  errors;
		int                  messages_closed;
		int                  digests_seen;

		function new();
			foreach (blk[i]) blk[i] = 8'h00;
			errors = 0;
			messages_closed = 0;
			digests_seen = 0;
			restart();
		endfunction

		function void restart();
			foreach (chain[i]) chain[i] = START_WORDS[i];
			fill = 0;
			bits_done = '0;
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function void compress_block();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] t1, t2, s0, s1;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 64; i++) begin
				s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = s1 + w[i-7] + s0 + w[i-16];
			end
			v = chain;
			for (int i = 0; i < 64; i++) begin
				t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
				t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		// Called on every accepted input transfer; queues a digest on end of message.
		function void note_item(sha256_pkg::item_t it);
			logic [63:0]         total;
			sha256_pkg::digest_t d;
			if (it.has_byte) begin
				blk[fill] = it.msg_byte;
				fill = (fill + 1) % 64;
				if (fill == 0) begin
					compress_block();
					bits_done = bits_done + 64'd512;
				end
			end
			if (!it.end_of_msg)
				return;
			total = bits_done + 64'(fill * 8);
			blk[fill] = 8'h80;
			fill++;
			// no room for the length field: pad out and run an extra block
			if (fill > 56) begin
				while (fill < 64) begin
					blk[fill] = 8'h00;
					fill++;
				end
				compress_block();
				fill = 0;
			end
			while (fill < 56) begin
				blk[fill] = 8'h00;
				fill++;
			end
			for (int i = 0; i < 8; i++)
				blk[56+i] = total[8*(7-i) +: 8];
			compress_block();
			d.digest_bits_255_192 = {chain[0], chain[1]};
			d.digest_bits_191_128 = {chain[2], chain[3]};
			d.digest_bits_127_64  = {chain[4], chain[5]};
			d.digest_bits_63_0    = {chain[6], chain[7]};
			want_q.push_back(d);
			messages_closed++;
			restart();
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("digest %0d %s: expected %h got %h",
						digests_seen, name, want, got);
			end
		endfunction

		function void check_digest(sha256_pkg::digest_t got);
			sha256_pkg::digest_t want;
			digests_seen++;
			if (want_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("digest %0d: unexpected transfer %h", digests_seen, got);
				return;
			end
			want = want_q.pop_front();
			check_field("bits 255:192", want.digest_bits_255_192, got.digest_bits_255_192);
			check_field("bits 191:128", want.digest_bits_191_128, got.digest_bits_191_128);
			check_field("bits 127:64", want.digest_bits_127_64, got.digest_bits_127_64);
			check_field("bits 63:0", want.digest_bits_63_0, got.digest_bits_63_0);
		endfunction
	endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int ITEM_TARGET = 1150;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 300;
	localparam int LONG_HOLD   = 400;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	sha256_pkg::item_t   item;
	logic                digest_valid;
	logic                digest_ready;
	sha256_pkg::digest_t digest;

	sha256_digest_check_pkg::digest_scoreboard sb;
	int items_sent = 0;
	int stall_cycles = 0;

	sha256_byte_stream_hasher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// no transfer on either side for too long means the block is hung
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (digest_valid && digest_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL sha256_byte_stream_hasher");
				$finish;
			end
		end
	end

	// Digest sink: random back-pressure, with a long hold at the start and mid-run.
	initial begin : digest_sink
		int gap;
		int taken;
		taken = 0;
		digest_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 0 || taken == 20)
				gap = LONG_HOLD;
			else if ($urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(0, 16);
			repeat (gap) begin
				@(negedge clk);
				digest_ready = 1'b0;
			end
			@(negedge clk);
			digest_ready = 1'b1;
			do @(posedge clk); while (!digest_valid);
			sb.check_digest(digest);
			taken++;
		end
	end

	function automatic sha256_pkg::item_t make_item(logic [7:0] b, logic hb, logic eom);
		sha256_pkg::item_t it;
		it.msg_byte   = b;
		it.has_byte   = hb;
		it.end_of_msg = eom;
		return it;
	endfunction

	function automatic int pick_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	// Starts and ends just after a rising edge.
	task automatic send_item(sha256_pkg::item_t it, int gap);
		repeat (gap) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		@(negedge clk);
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		if (it.has_byte || it.end_of_msg)
			items_sent++;
	endtask

	task automatic send_message(int len, bit burst);
		bit close_with_byte;
		close_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(make_item(8'($urandom), 1'b0, 1'b0), pick_gap(burst));
			send_item(make_item(8'($urandom), 1'b1, close_with_byte && (k == len - 1)),
				pick_gap(burst));
		end
		if (!close_with_byte)
			send_item(make_item(8'($urandom), 1'b0, 1'b1), pick_gap(burst));
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int len;
		int pick;
		int sizes [9];
		sizes = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// back-to-back empty messages while the sink holds off: fills the digest path
		repeat (4) send_item(make_item(8'h00, 1'b0, 1'b1), 0);
		// idle item, then byte and end in one transfer
		send_item(make_item(8'hff, 1'b0, 1'b0), pick_gap(0));
		send_item(make_item(8'h00, 1'b1, 1'b1), pick_gap(0));
		// byte, then closed by an empty end marker
		send_item(make_item(8'hff, 1'b1, 1'b0), pick_gap(0));
		send_item(make_item(8'h5a, 1'b0, 1'b1), pick_gap(0));
		// "abc"
		send_item(make_item(8'h61, 1'b1, 1'b0), pick_gap(0));
		send_item(make_item(8'h62, 1'b1, 1'b0), pick_gap(0));
		send_item(make_item(8'h63, 1'b1, 1'b1), pick_gap(0));
		// idle item inside a message
		send_item(make_item(8'h78, 1'b1, 1'b0), pick_gap(0));
		send_item(make_item(8'ha5, 1'b0, 1'b0), pick_gap(0));
		send_item(make_item(8'h79, 1'b1, 1'b1), pick_gap(0));
		drain();

		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				len = $urandom_range(0, 8);
			else if (pick < 8)
				len = sizes[$urandom_range(0, 8)];
			else
				len = $urandom_range(0, 140);
			send_message(len, $urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS sha256_byte_stream_hasher");
		else
			$display("FAIL sha256_byte_stream_hasher");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sha256_pkg.sv
design/sha256_round.sv
design/sha256_core.sv
design/sha256_byte_stream_hasher.sv
tb/sha256_digest_check_pkg.sv
tb/tb.sv
